/* rtl/b64d_pkg.sv */
// Shared types, constants and the character decode function for the
// Base64 decoder. No dependencies.
package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned AccW    = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PadW    = 3;
  localparam int unsigned CntW    = 2;
  localparam int unsigned NbW     = 2;

  localparam logic [CharW-1:0] PadChar = 8'h3D;
  localparam logic [PadW-1:0]  PadMax  = 3'd4;

  // Job queue between front and back end
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadChar = 2'd1,
    StBadLen  = 2'd2
  } status_e;

  // Result of classifying one character
  typedef struct packed {
    logic               valid;  // part of alphabet or pad
    logic               pad;    // '='
    logic [SextetW-1:0] value;
  } sextet_t;

  // One unit of work for the back end: 1..3 results
  typedef struct packed {
    status_e         status;
    logic [AccW-1:0] acc;
    logic [NbW-1:0]  nbytes;
  } job_t;

  function automatic sextet_t decode_char(input logic [CharW-1:0] c);
    sextet_t s;
    s = '{valid: 1'b0, pad: 1'b0, value: '0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.valid = 1'b1;
      s.value = SextetW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.valid = 1'b1;
      s.value = SextetW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.valid = 1'b1;
      s.value = SextetW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.valid = 1'b1;
      s.value = 6'd62;
    end else if (c == 8'h2F) begin
      s.valid = 1'b1;
      s.value = 6'd63;
    end else if (c == PadChar) begin
      s.valid = 1'b1;
      s.pad   = 1'b1;
    end
    return s;
  endfunction

endpackage

/* rtl/b64d_front.sv */
// Front end: accepts characters, keeps group state, pushes jobs.
// Depends on b64d_pkg.
module b64d_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [b64d_pkg::CharW-1:0]   char_code_i,
  input  logic                         end_of_text_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output b64d_pkg::job_t               q_job_o
);
  import b64d_pkg::*;

  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PadW-1:0] pad_q, pad_d;
  logic            drop_q, drop_d;
  logic            take;
  sextet_t         sx;
  logic [AccW-1:0] acc_sh;
  logic [PadW-1:0] pad_n;
  logic [NbW-1:0]  nb;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign sx         = decode_char(char_code_i);
  // a pad decodes to a zero value, so it shifts in zero
  assign acc_sh     = {acc_q[AccW-SextetW-1:0], sx.value};
  assign pad_n      = (sx.pad && pad_q < PadMax) ? pad_q + 3'd1 : pad_q;
  assign nb         = (pad_n >= 3'd2) ? 2'd1 : (pad_n == 3'd1) ? 2'd2 : 2'd3;

  always_comb begin
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    pad_d    = pad_q;
    drop_d   = drop_q;
    q_push_o = 1'b0;
    q_job_o  = '{status: StOk, acc: '0, nbytes: 2'd1};
    if (take) begin
      if (drop_q) begin
        if (end_of_text_i) drop_d = 1'b0;
      end else if (!sx.valid) begin
        q_push_o = 1'b1;
        q_job_o  = '{status: StBadChar, acc: '0, nbytes: 2'd1};
        acc_d    = '0;
        cnt_d    = '0;
        pad_d    = '0;
        drop_d   = !end_of_text_i;
      end else if (cnt_q == 2'd3) begin
        q_push_o = 1'b1;
        q_job_o  = '{status: StOk, acc: acc_sh, nbytes: nb};
        acc_d    = '0;
        cnt_d    = '0;
        pad_d    = '0;
      end else if (end_of_text_i) begin
        q_push_o = 1'b1;
        q_job_o  = '{status: StBadLen, acc: '0, nbytes: 2'd1};
        acc_d    = '0;
        cnt_d    = '0;
        pad_d    = '0;
      end else begin
        acc_d = acc_sh;
        cnt_d = cnt_q + 2'd1;
        pad_d = pad_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      pad_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      pad_q  <= pad_d;
      drop_q <= drop_d;
    end
  end

endmodule

/* rtl/b64d_queue.sv */
// Short job queue between front and back end, flop based.
// Depends on b64d_pkg.
module b64d_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output b64d_pkg::job_t job_o
);
  import b64d_pkg::*;

  job_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* rtl/b64d_back.sv */
// Back end: holds one job and issues its results one per cycle while out_ready_i is high.
// Depends on b64d_pkg.
module b64d_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  b64d_pkg::job_t              q_job_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [b64d_pkg::ByteW-1:0]  data_byte_o,
  output logic [1:0]                  status_o,
  output logic                        last_in_run_o
);
  import b64d_pkg::*;

  job_t           job_q;
  logic           busy_q;
  logic [NbW-1:0] idx_q;
  logic           last;
  logic           done;

  assign last    = (idx_q == job_q.nbytes - 2'd1);
  assign done    = busy_q && out_ready_i && last;
  assign q_pop_o = !q_empty_i && (!busy_q || done);

  always_comb begin
    case (idx_q)
      2'd0:    data_byte_o = job_q.acc[23:16];
      2'd1:    data_byte_o = job_q.acc[15:8];
      default: data_byte_o = job_q.acc[7:0];
    endcase
  end

  assign out_valid_o   = busy_q;
  assign status_o      = job_q.status;
  assign last_in_run_o = last;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

/* rtl/base64_decoder.sv */
// Top level of the streaming Base64 decoder.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
// Streaming Base64 (standard alphabet) decoder. One character is taken per
// input transaction, with end_of_text_i marking the last character of a
// string. Every fourth character closes a group, which yields one to three
// bytes depending on how many '=' pads the group held; the last result of
// a group carries last_in_run_o. A character outside the alphabet yields a
// single invalid-character result, after which characters are dropped up
// to and including the next end marker. An end marker that does not close
// a group yields a length-error result. Error results carry data byte zero.
// Throughput: one character per cycle, sustained. The front end classifies
// a character in the cycle it is accepted and pushes at most one job into
// a four-entry queue; the back end drains one result per cycle while
// out_ready_i is high; a valid group yields at most three results. A job
// is registered in the queue, then in the back end, before its first result.
// in_ready_o drops only while the queue is full, i.e. under sustained output backpressure.
module base64_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // character channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [b64d_pkg::CharW-1:0]  char_code_i,
  input  logic                        end_of_text_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [b64d_pkg::ByteW-1:0]  data_byte_o,
  output logic [1:0]                  status_o,
  output logic                        last_in_run_o
);
  import b64d_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, pop_job;

  // character classification and group state
  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (push_job)
  );

  // decouples the two ends so each can stall on its own
  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (pop_job)
  );

  // result sequencing
  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_job_i       (pop_job),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .status_o      (status_o),
    .last_in_run_o (last_in_run_o)
  );

endmodule
